@@ rtl/dtp_pkg.sv @@
// dtp_pkg: widths, constants, register codes and helpers for the depth to point cloud unit
// no dependencies; used by the channel interfaces, the unit and its checker
`timescale 1ns / 1ps
`default_nettype none

package dtp_pkg;

  // payload widths
  localparam int DepthW   = 16;
  localparam int CoordW   = 10;
  localparam int DimW     = 11;
  localparam int PointW   = 28;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 63;
  localparam int RotRowW  = 48;
  localparam int TransW   = 63;

  // frame size limits
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;

  // normalised coordinate and reciprocal
  localparam int NormFracBits = 16;
  localparam int QW           = CoordW + NormFracBits;  // quotient width
  localparam int MW           = QW + 1;                 // reciprocal width
  localparam int CntW         = $clog2(MW);
  localparam int HalfNorm     = 2 ** (NormFracBits - 1);

  // camera scaling
  localparam int KW         = 21;
  localparam int PzW        = QW + DepthW;
  localparam int PzHalfW    = PzW / 2;
  localparam int ScaleShift = 32;
  localparam int SumW       = 64;
  localparam int MagW       = 31;
  localparam int PW         = MagW + 1;
  localparam logic [KW-1:0] KScale [2] = '{21'd1165457, 21'd874093};

  // rigid transform
  localparam int CoefW        = 16;
  localparam int CoefFracBits = 14;
  localparam int TCompW       = 21;
  localparam int ProdW        = CoefW + PW;
  localparam int AccW         = ProdW + 2;
  localparam int RndW         = AccW - CoefFracBits;
  localparam int FinW         = RndW + 1;

  // output saturation
  localparam int OutMax = 2 ** (PointW - 1) - 1;
  localparam int OutMin = -(2 ** (PointW - 1));

  // pipeline depth from accepted beat to output register
  localparam int NStages = 13;

  // register reset values
  localparam logic [DimW-1:0]    WidthReset  = 11'd320;
  localparam logic [DimW-1:0]    HeightReset = 11'd240;
  localparam logic [RotRowW-1:0] RotReset [3] = '{
    48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000
  };

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH      = 3'd0,
    CFG_FRAME_HEIGHT     = 3'd1,
    CFG_TRANSFORM_ENABLE = 3'd2,
    CFG_ROT_ROW0         = 3'd3,
    CFG_ROT_ROW1         = 3'd4,
    CFG_ROT_ROW2         = 3'd5,
    CFG_TRANSLATION      = 3'd6
  } cfg_idx_t;

  // zero counts as one, anything over the limit is the limit
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d,
                                                input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    if (d == '0) begin
      r = DimW'(1);
    end else if (d > maxv) begin
      r = maxv;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dtp_if.sv @@
// dtp channel interfaces: depth sample input, point output and register write port
// depends on dtp_pkg for payload widths
`timescale 1ns / 1ps
`default_nettype none

interface dtp_in_if;
  logic                       valid;
  logic                       ready;
  logic [dtp_pkg::DepthW-1:0] depth;
  logic [dtp_pkg::CoordW-1:0] row;
  logic [dtp_pkg::CoordW-1:0] col;

  modport source (output valid, depth, row, col, input ready);
  modport sink   (input valid, depth, row, col, output ready);
endinterface

interface dtp_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dtp_pkg::PointW-1:0] point_x;
  logic signed [dtp_pkg::PointW-1:0] point_y;
  logic signed [dtp_pkg::PointW-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface dtp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dtp_pkg::CfgIdxW-1:0]  index;
  logic [dtp_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/depth_to_point_cloud_unit.sv @@
// depth_to_point_cloud_unit: pinhole back-projection of depth samples with optional rigid transform
// depends on dtp_pkg and the channel interfaces in dtp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   in_ch  : one depth sample per beat (depth, row, col), valid/ready
//   out_ch : one point per beat (point_x, point_y, point_z, signed, 4 fraction bits)
//   cfg_ch : register writes (index, data), always ready; write only while idle
// Throughput: one beat per cycle while the divider is idle and out_ch is not stalled,
//   set by a 13-stage pipeline with one stage per multiply, wide add or rounding step.
// Path: out_ch.valid rises once a taken beat has moved through stages 0 to 12 in order.
// Reset: the reciprocals of frame width and height are rebuilt by a bit-serial
//   divider, one quotient bit per cycle; in_ch.ready stays low after reset is
//   released and after each write of width or height until the divider is idle.
// Stall: when out_ch.ready is low the output register holds its point; earlier
//   stages keep filling bubbles, and in_ch.ready drops only once every stage holds
//   a beat. Nothing is dropped or repeated.
module depth_to_point_cloud_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dtp_in_if.sink      in_ch,
  dtp_out_if.source   out_ch,
  dtp_cfg_if.sink     cfg_ch
);

  localparam int NS = dtp_pkg::NStages;

  typedef enum logic [1:0] {DIV_LOAD, DIV_RUN, DIV_IDLE} div_state_t;

  // configuration registers
  logic [dtp_pkg::DimW-1:0]    width_r;
  logic [dtp_pkg::DimW-1:0]    height_r;
  logic                        xform_en_r;
  logic [dtp_pkg::RotRowW-1:0] rot_r [3];
  logic [dtp_pkg::TransW-1:0]  trans_r;

  logic cfg_fire;
  logic dim_wr;
  logic [dtp_pkg::DimW-1:0] dim [2];

  // reciprocal divider
  div_state_t               div_state_r;
  logic [dtp_pkg::CntW-1:0] div_cnt_r;
  logic [dtp_pkg::DimW-1:0] div_rem_r   [2];
  logic [dtp_pkg::MW-1:0]   recip_r     [2];
  logic [dtp_pkg::DimW-1:0] div_rem_nxt [2];
  logic [dtp_pkg::MW-1:0]   recip_nxt   [2];
  logic                     div_bit;
  logic                     busy;

  // pipeline control
  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy_s;
  logic          in_fire;

  // stage payloads; lane 0 is x (column), lane 1 is y (row)
  logic [dtp_pkg::DepthW-1:0]  s0_z_r;
  logic [dtp_pkg::CoordW-1:0]  s0_crd_r [2];
  logic [dtp_pkg::DepthW-1:0]  s1_z_r;
  logic [dtp_pkg::CoordW-1:0]  s1_crd_r [2];
  logic [dtp_pkg::QW-1:0]      s1_q0_r  [2];
  logic [dtp_pkg::DepthW-1:0]  s2_z_r;
  logic [dtp_pkg::CoordW-1:0]  s2_crd_r [2];
  logic [dtp_pkg::QW-1:0]      s2_q0_r  [2];
  logic [dtp_pkg::QW-1:0]      s2_qd_r  [2];
  logic [dtp_pkg::DepthW-1:0]  s3_z_r;
  logic [dtp_pkg::QW-1:0]      s3_q_r   [2];
  logic [dtp_pkg::DepthW-1:0]  s4_z_r;
  logic [dtp_pkg::QW-1:0]      s4_mag_r [2];
  logic                        s4_neg_r [2];
  logic [dtp_pkg::DepthW-1:0]  s5_z_r;
  logic [dtp_pkg::PzW-1:0]     s5_pz_r  [2];
  logic                        s5_neg_r [2];
  logic [dtp_pkg::DepthW-1:0]  s6_z_r;
  logic [dtp_pkg::PzW-1:0]     s6_lo_r  [2];
  logic [dtp_pkg::PzW-1:0]     s6_hi_r  [2];
  logic                        s6_neg_r [2];
  logic [dtp_pkg::DepthW-1:0]  s7_z_r;
  logic [dtp_pkg::MagW-1:0]    s7_mag_r [2];
  logic                        s7_neg_r [2];
  logic signed [dtp_pkg::PW-1:0]    s8_p_r    [3];
  logic signed [dtp_pkg::ProdW-1:0] s9_prod_r [3][3];
  logic signed [dtp_pkg::PW-1:0]    s9_p_r    [3];
  logic signed [dtp_pkg::AccW-1:0]  s10_acc_r [3];
  logic signed [dtp_pkg::PW-1:0]    s10_p_r   [3];
  logic signed [dtp_pkg::RndW-1:0]  s11_rnd_r [3];
  logic signed [dtp_pkg::PW-1:0]    s11_p_r   [3];
  logic signed [dtp_pkg::PointW-1:0] point_r  [3];

  // stage combinational values
  logic [dtp_pkg::CoordW+dtp_pkg::MW-1:0]   q0_prod_nxt [2];
  logic [dtp_pkg::QW+dtp_pkg::DimW-1:0]     qd_prod_nxt [2];
  logic [dtp_pkg::QW-1:0]                   rem_nxt     [2];
  logic [dtp_pkg::QW-1:0]                   q_nxt       [2];
  logic [dtp_pkg::SumW-1:0]                 full_nxt    [2];
  logic signed [dtp_pkg::PW-1:0]            p_nxt       [3];
  logic signed [dtp_pkg::AccW-1:0]          acc_b_nxt   [3];
  logic signed [dtp_pkg::TCompW-1:0]        t_comp      [3];
  logic signed [dtp_pkg::FinW-1:0]          fin_nxt     [3];
  logic signed [dtp_pkg::PointW-1:0]        point_nxt   [3];

  // ---------------------------------------------------------------------------
  // configuration port
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;
  assign dim_wr = cfg_fire &&
                  ((cfg_ch.index == dtp_pkg::CfgIdxW'(dtp_pkg::CFG_FRAME_WIDTH)) ||
                   (cfg_ch.index == dtp_pkg::CfgIdxW'(dtp_pkg::CFG_FRAME_HEIGHT)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= dtp_pkg::WidthReset;
      height_r   <= dtp_pkg::HeightReset;
      xform_en_r <= 1'b0;
      rot_r[0]   <= dtp_pkg::RotReset[0];
      rot_r[1]   <= dtp_pkg::RotReset[1];
      rot_r[2]   <= dtp_pkg::RotReset[2];
      trans_r    <= '0;
    end else if (cfg_fire) begin
      unique case (dtp_pkg::cfg_idx_t'(cfg_ch.index))
        dtp_pkg::CFG_FRAME_WIDTH:      width_r    <= cfg_ch.data[dtp_pkg::DimW-1:0];
        dtp_pkg::CFG_FRAME_HEIGHT:     height_r   <= cfg_ch.data[dtp_pkg::DimW-1:0];
        dtp_pkg::CFG_TRANSFORM_ENABLE: xform_en_r <= cfg_ch.data[0];
        dtp_pkg::CFG_ROT_ROW0:         rot_r[0]   <= cfg_ch.data[dtp_pkg::RotRowW-1:0];
        dtp_pkg::CFG_ROT_ROW1:         rot_r[1]   <= cfg_ch.data[dtp_pkg::RotRowW-1:0];
        dtp_pkg::CFG_ROT_ROW2:         rot_r[2]   <= cfg_ch.data[dtp_pkg::RotRowW-1:0];
        dtp_pkg::CFG_TRANSLATION:      trans_r    <= cfg_ch.data[dtp_pkg::TransW-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamped frame dimensions
  assign dim[0] = dtp_pkg::clamp_dim(width_r,  dtp_pkg::DimW'(dtp_pkg::MaxWidth));
  assign dim[1] = dtp_pkg::clamp_dim(height_r, dtp_pkg::DimW'(dtp_pkg::MaxHeight));

  // ---------------------------------------------------------------------------
  // bit-serial reciprocal: recip = floor(2^QW / dim), one quotient bit a cycle
  assign div_bit = (div_cnt_r == '0);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [dtp_pkg::DimW:0] sh;
      logic                   ge;
      sh = {div_rem_r[l], div_bit};
      ge = (sh >= {1'b0, dim[l]});
      div_rem_nxt[l] = ge ? dtp_pkg::DimW'(sh - {1'b0, dim[l]}) : sh[dtp_pkg::DimW-1:0];
      recip_nxt[l]   = {recip_r[l][dtp_pkg::MW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_state_r <= DIV_LOAD;
    end else if (dim_wr) begin
      div_state_r <= DIV_LOAD;
    end else begin
      unique case (div_state_r)
        DIV_LOAD: begin
          div_cnt_r    <= '0;
          div_rem_r[0] <= '0;
          div_rem_r[1] <= '0;
          recip_r[0]   <= '0;
          recip_r[1]   <= '0;
          div_state_r  <= DIV_RUN;
        end
        DIV_RUN: begin
          div_cnt_r    <= div_cnt_r + dtp_pkg::CntW'(1);
          div_rem_r[0] <= div_rem_nxt[0];
          div_rem_r[1] <= div_rem_nxt[1];
          recip_r[0]   <= recip_nxt[0];
          recip_r[1]   <= recip_nxt[1];
          if (div_cnt_r == dtp_pkg::CntW'(dtp_pkg::QW)) begin
            div_state_r <= DIV_IDLE;
          end
        end
        DIV_IDLE: begin
        end
        default: div_state_r <= DIV_LOAD;
      endcase
    end
  end

  assign busy = (div_state_r != DIV_IDLE);

  // ---------------------------------------------------------------------------
  // pipeline handshake: a stage takes a beat when empty or when the next one moves
  always_comb begin
    rdy_s[NS-1] = !v_r[NS-1] || out_ch.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy_s[k] = !v_r[k] || rdy_s[k+1];
    end
  end

  assign in_ch.ready = rdy_s[0] && !busy;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy_s[0]) begin
        v_r[0] <= in_fire;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy_s[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: capture the beat
  always_ff @(posedge clk) begin
    if (rdy_s[0]) begin
      s0_z_r      <= in_ch.depth;
      s0_crd_r[0] <= in_ch.col;
      s0_crd_r[1] <= in_ch.row;
    end
  end

  // stage 1: quotient estimate, coord * 2^16 * recip / 2^QW
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q0_prod_nxt[l] = s0_crd_r[l] * recip_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s[1]) begin
      s1_z_r <= s0_z_r;
      for (int l = 0; l < 2; l++) begin
        s1_crd_r[l] <= s0_crd_r[l];
        s1_q0_r[l]  <= q0_prod_nxt[l][dtp_pkg::CoordW+dtp_pkg::QW-1:dtp_pkg::CoordW];
      end
    end
  end

  // stage 2: estimate times divisor
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qd_prod_nxt[l] = s1_q0_r[l] * dim[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s[2]) begin
      s2_z_r <= s1_z_r;
      for (int l = 0; l < 2; l++) begin
        s2_crd_r[l] <= s1_crd_r[l];
        s2_q0_r[l]  <= s1_q0_r[l];
        s2_qd_r[l]  <= qd_prod_nxt[l][dtp_pkg::QW-1:0];
      end
    end
  end

  // stage 3: the estimate is short by at most one
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_nxt[l] = {s2_crd_r[l], dtp_pkg::NormFracBits'(0)} - s2_qd_r[l];
      q_nxt[l]   = s2_q0_r[l] + dtp_pkg::QW'(rem_nxt[l] >= dtp_pkg::QW'(dim[l]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s[3]) begin
      s3_z_r    <= s2_z_r;
      s3_q_r[0] <= q_nxt[0];
      s3_q_r[1] <= q_nxt[1];
    end
  end

  // stage 4: magnitude of the offset from the centre and sign of the point
  always_ff @(posedge clk) begin
    if (rdy_s[4]) begin
      s4_z_r <= s3_z_r;
      for (int l = 0; l < 2; l++) begin
        s4_mag_r[l] <= (s3_q_r[l] >= dtp_pkg::QW'(dtp_pkg::HalfNorm)) ?
                       s3_q_r[l] - dtp_pkg::QW'(dtp_pkg::HalfNorm) :
                       dtp_pkg::QW'(dtp_pkg::HalfNorm) - s3_q_r[l];
      end
      // x is mirrored: right of centre gives negative x; y is negative below centre
      s4_neg_r[0] <= (s3_q_r[0] >= dtp_pkg::QW'(dtp_pkg::HalfNorm));
      s4_neg_r[1] <= (s3_q_r[1] >  dtp_pkg::QW'(dtp_pkg::HalfNorm));
    end
  end

  // stage 5: magnitude times depth
  always_ff @(posedge clk) begin
    if (rdy_s[5]) begin
      s5_z_r <= s4_z_r;
      for (int l = 0; l < 2; l++) begin
        s5_pz_r[l]  <= s4_mag_r[l] * s4_z_r;
        s5_neg_r[l] <= s4_neg_r[l];
      end
    end
  end

  // stage 6: focal scale as two half-width partial products
  always_ff @(posedge clk) begin
    if (rdy_s[6]) begin
      s6_z_r <= s5_z_r;
      for (int l = 0; l < 2; l++) begin
        s6_lo_r[l]  <= s5_pz_r[l][dtp_pkg::PzHalfW-1:0] * dtp_pkg::KScale[l];
        s6_hi_r[l]  <= s5_pz_r[l][dtp_pkg::PzW-1:dtp_pkg::PzHalfW] * dtp_pkg::KScale[l];
        s6_neg_r[l] <= s5_neg_r[l];
      end
    end
  end

  // stage 7: join partials and round half up on the magnitude
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      full_nxt[l] = {1'b0, s6_hi_r[l], dtp_pkg::PzHalfW'(0)} +
                    dtp_pkg::SumW'(s6_lo_r[l]) +
                    (dtp_pkg::SumW'(1) << (dtp_pkg::ScaleShift - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s[7]) begin
      s7_z_r <= s6_z_r;
      for (int l = 0; l < 2; l++) begin
        s7_mag_r[l] <= full_nxt[l][dtp_pkg::ScaleShift+dtp_pkg::MagW-1:dtp_pkg::ScaleShift];
        s7_neg_r[l] <= s6_neg_r[l];
      end
    end
  end

  // stage 8: apply sign; z is depth with four fraction bits
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      p_nxt[l] = s7_neg_r[l] ? -$signed({1'b0, s7_mag_r[l]}) : $signed({1'b0, s7_mag_r[l]});
    end
    p_nxt[2] = $signed(dtp_pkg::PW'({s7_z_r, 4'b0000}));
  end

  always_ff @(posedge clk) begin
    if (rdy_s[8]) begin
      s8_p_r[0] <= p_nxt[0];
      s8_p_r[1] <= p_nxt[1];
      s8_p_r[2] <= p_nxt[2];
    end
  end

  // stage 9: rotation products, one per coefficient
  always_ff @(posedge clk) begin
    if (rdy_s[9]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s9_prod_r[i][j] <= $signed(rot_r[i][dtp_pkg::CoefW*j +: dtp_pkg::CoefW]) * s8_p_r[j];
        end
        s9_p_r[i] <= s8_p_r[i];
      end
    end
  end

  // stage 10: row sums
  always_ff @(posedge clk) begin
    if (rdy_s[10]) begin
      for (int i = 0; i < 3; i++) begin
        s10_acc_r[i] <= dtp_pkg::AccW'(s9_prod_r[i][0]) + dtp_pkg::AccW'(s9_prod_r[i][1]) +
                        dtp_pkg::AccW'(s9_prod_r[i][2]);
        s10_p_r[i]   <= s9_p_r[i];
      end
    end
  end

  // stage 11: drop coefficient fraction, half away from zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_b_nxt[i] = s10_acc_r[i] + (dtp_pkg::AccW'(1) << (dtp_pkg::CoefFracBits - 1)) -
                     dtp_pkg::AccW'(s10_acc_r[i][dtp_pkg::AccW-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s[11]) begin
      for (int i = 0; i < 3; i++) begin
        s11_rnd_r[i] <= acc_b_nxt[i][dtp_pkg::AccW-1:dtp_pkg::CoefFracBits];
        s11_p_r[i]   <= s10_p_r[i];
      end
    end
  end

  // stage 12: translation, bypass select and saturation into the output register
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_comp[i]  = trans_r[dtp_pkg::TCompW*i +: dtp_pkg::TCompW];
      fin_nxt[i] = xform_en_r ?
                   dtp_pkg::FinW'(s11_rnd_r[i]) + dtp_pkg::FinW'($signed({t_comp[i], 4'b0000})) :
                   dtp_pkg::FinW'(s11_p_r[i]);
      if (fin_nxt[i] > dtp_pkg::FinW'(dtp_pkg::OutMax)) begin
        point_nxt[i] = dtp_pkg::PointW'(dtp_pkg::OutMax);
      end else if (fin_nxt[i] < dtp_pkg::FinW'(dtp_pkg::OutMin)) begin
        point_nxt[i] = dtp_pkg::PointW'(dtp_pkg::OutMin);
      end else begin
        point_nxt[i] = fin_nxt[i][dtp_pkg::PointW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s[12]) begin
      point_r[0] <= point_nxt[0];
      point_r[1] <= point_nxt[1];
      point_r[2] <= point_nxt[2];
    end
  end

  assign out_ch.valid   = v_r[NS-1];
  assign out_ch.point_x = point_r[0];
  assign out_ch.point_y = point_r[1];
  assign out_ch.point_z = point_r[2];

endmodule

`default_nettype wire

@@ rtl/dtp_checker.sv @@
// dtp_checker: port-level assertions for depth_to_point_cloud_unit, attached by bind
// depends on dtp_pkg and on the unit's channel interface ports
`timescale 1ns / 1ps
`default_nettype none

module dtp_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [dtp_pkg::PointW-1:0] point_x,
  input wire logic signed [dtp_pkg::PointW-1:0] point_y,
  input wire logic signed [dtp_pkg::PointW-1:0] point_z,
  input wire logic                              cfg_valid,
  input wire logic                              cfg_ready,
  input wire logic [dtp_pkg::CfgIdxW-1:0]       cfg_index
);

  localparam int FlightW = $clog2(dtp_pkg::NStages + 1);

  logic [FlightW-1:0] inflight_r;
  logic               in_beat;
  logic               out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // beats taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (in_beat && !out_beat) begin
      inflight_r <= inflight_r + FlightW'(1);
    end else if (out_beat && !in_beat) begin
      inflight_r <= inflight_r - FlightW'(1);
    end
  end

  // reciprocals are rebuilt straight after reset
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("input ready while reciprocals rebuild after reset");

  // a frame size write restarts the divider and blocks input
  a_busy_after_dim_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready &&
     ((cfg_index == dtp_pkg::CfgIdxW'(dtp_pkg::CFG_FRAME_WIDTH)) ||
      (cfg_index == dtp_pkg::CfgIdxW'(dtp_pkg::CFG_FRAME_HEIGHT)))) |=> !in_ready)
    else $error("input ready right after a frame size write");

  // no point without a sample behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (inflight_r != '0))
    else $error("output beat with no sample in flight");

  // occupancy never exceeds the pipeline depth
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= FlightW'(dtp_pkg::NStages))
    else $error("more beats in flight than pipeline stages");

  // a stalled point stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(point_x) && $stable(point_y) && $stable(point_z)))
    else $error("output beat changed while stalled");

endmodule

bind depth_to_point_cloud_unit dtp_checker u_dtp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .point_x   (out_ch.point_x),
  .point_y   (out_ch.point_y),
  .point_z   (out_ch.point_z),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready),
  .cfg_index (cfg_ch.index)
);

`default_nettype wire

@@ test/testbench.sv @@
// testbench: self-checking bench for depth_to_point_cloud_unit (depth sample in, 3d point out)
// needs dtp_pkg, the channel interfaces in dtp_if.sv and the unit itself; reads nothing else
`timescale 1ns / 1ps

module testbench;
  import dtp_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int PhaseCount = 10;
  localparam int PhaseBeats = 65;

  typedef struct packed {
    logic signed [PointW-1:0] x;
    logic signed [PointW-1:0] y;
    logic signed [PointW-1:0] z;
  } point_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    cfg_idx_t            reg_idx;
    logic [CfgDataW-1:0] value;
    logic [DepthW-1:0]   depth;
    logic [CoordW-1:0]   row;
    logic [CoordW-1:0]   col;
    logic                pinned;
    point_t              want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  dtp_in_if  in_ch ();
  dtp_out_if out_ch ();
  dtp_cfg_if cfg_ch ();

  depth_to_point_cloud_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the unit's registers, kept in step with every write beat
  logic [DimW-1:0]    frame_w    = 11'd320;
  logic [DimW-1:0]    frame_h    = 11'd240;
  logic               xform_on   = 1'b0;
  logic [RotRowW-1:0] rot_rows [3] = '{48'h0000_0000_4000, 48'h0000_4000_0000,
                                       48'h4000_0000_0000};
  logic [TransW-1:0]  trans_offs = '0;

  point_t pending_points [$];
  point_t head_point;
  stim_row_t plan [$];

  int  send_idle_pct = 0;
  int  stall_pct     = 0;
  int  mismatch_count = 0;
  int  points_seen   = 0;
  int  cycle_count   = 0;

  // a typed-in expectation travels with the beat it belongs to
  logic   pin_on;
  point_t pin_point;

  // zero counts as one, anything over the limit is the limit
  function automatic longint active_extent(logic [DimW-1:0] d, int lim);
    if (d == '0) return 1;
    if (d > lim) return lim;
    return longint'(d);
  endfunction

  // round(n * z * k / 2^32), half away from zero, on the magnitude
  function automatic longint scaled_round(longint n, longint unsigned zv,
                                          longint unsigned k);
    longint unsigned mag;
    mag = (n < 0) ? -n : n;
    mag = (mag * zv * k + 64'h8000_0000) >> 32;
    return (n < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // back-project one sample and apply the optional rigid transform
  function automatic point_t project_sample(logic [DepthW-1:0] zd, logic [CoordW-1:0] r,
                                            logic [CoordW-1:0] c);
    longint w;
    longint h;
    longint nx;
    longint ny;
    longint acc;
    longint coef;
    longint half_lsb;
    longint cam [3];
    longint res [3];
    point_t pt;
    w  = active_extent(frame_w, MaxWidth);
    h  = active_extent(frame_h, MaxHeight);
    nx = (longint'(c) <<< NormFracBits) / w - HalfNorm;
    ny = HalfNorm - (longint'(r) <<< NormFracBits) / h;
    cam[0] = -scaled_round(nx, zd, KScale[0]);
    cam[1] = scaled_round(ny, zd, KScale[1]);
    cam[2] = longint'(zd) * 16;
    half_lsb = longint'(1) <<< (CoefFracBits - 1);
    for (int i = 0; i < 3; i++) begin
      if (xform_on) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          coef = longint'($signed(rot_rows[i][16*j +: 16]));
          acc += coef * cam[j];
        end
        if (acc < 0) begin
          acc = -((-acc + half_lsb) >>> CoefFracBits);
        end else begin
          acc = (acc + half_lsb) >>> CoefFracBits;
        end
        acc += longint'($signed(trans_offs[TCompW*i +: TCompW])) * 16;
      end else begin
        acc = cam[i];
      end
      if (acc > OutMax) acc = OutMax;
      if (acc < OutMin) acc = OutMin;
      res[i] = acc;
    end
    pt.x = PointW'(res[0]);
    pt.y = PointW'(res[1]);
    pt.z = PointW'(res[2]);
    return pt;
  endfunction

  function automatic stim_row_t sample_row(logic [DepthW-1:0] d, logic [CoordW-1:0] r,
                                           logic [CoordW-1:0] c);
    stim_row_t s;
    s = '{kind: ROW_SAMPLE, reg_idx: CFG_FRAME_WIDTH, value: '0, depth: d, row: r,
          col: c, pinned: 1'b0, want: '0};
    return s;
  endfunction

  function automatic stim_row_t pinned_row(logic [DepthW-1:0] d, logic [CoordW-1:0] r,
                                           logic [CoordW-1:0] c, int px, int py, int pz);
    stim_row_t s;
    s = sample_row(d, r, c);
    s.pinned = 1'b1;
    s.want.x = PointW'(px);
    s.want.y = PointW'(py);
    s.want.z = PointW'(pz);
    return s;
  endfunction

  function automatic stim_row_t write_row(cfg_idx_t idx, logic [CfgDataW-1:0] v);
    stim_row_t s;
    s = sample_row('0, '0, '0);
    s.kind = ROW_WRITE;
    s.reg_idx = idx;
    s.value = v;
    return s;
  endfunction

  // frame sizes: ordinary ones, with zero, one, two, the limit and over-limit values
  function automatic logic [DimW-1:0] pick_dim();
    case ($urandom_range(9))
      0: return '0;
      1: return DimW'(1);
      2: return DimW'(2);
      3: return DimW'(MaxWidth);
      4: return '1;
      5: return DimW'($urandom_range(2047, 1025));
      default: return DimW'($urandom_range(640, 16));
    endcase
  endfunction

  function automatic logic [CoefW-1:0] pick_coef();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h4000;
      4: return 16'hC000;
      default: return CoefW'($urandom);
    endcase
  endfunction

  function automatic logic [RotRowW-1:0] pick_rot_row();
    return {pick_coef(), pick_coef(), pick_coef()};
  endfunction

  // mostly inside the frame, sometimes anywhere in the field's range
  function automatic logic [CoordW-1:0] rand_coord(longint ext);
    if ($urandom_range(9) < 7) return CoordW'($urandom_range(int'(ext - 1), 0));
    return CoordW'($urandom_range(1023, 0));
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at point %0d: %s", points_seen, what);
    mismatch_count++;
  endtask

  // one sample beat, with an optional idle gap in front of it
  task automatic send_sample(logic [DepthW-1:0] d, logic [CoordW-1:0] r,
                             logic [CoordW-1:0] c, logic pinned, point_t want);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.depth <= d;
    in_ch.row   <= r;
    in_ch.col   <= c;
    pin_on      <= pinned;
    pin_point   <= want;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
  endtask

  // register write beat; the shadow copy follows once the beat is taken
  task automatic write_register(cfg_idx_t idx, logic [CfgDataW-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    forever begin
      @(posedge clk);
      if (cfg_ch.ready) break;
    end
    case (idx)
      CFG_FRAME_WIDTH:      frame_w = v[DimW-1:0];
      CFG_FRAME_HEIGHT:     frame_h = v[DimW-1:0];
      CFG_TRANSFORM_ENABLE: xform_on = v[0];
      CFG_ROT_ROW0:         rot_rows[0] = v[RotRowW-1:0];
      CFG_ROT_ROW1:         rot_rows[1] = v[RotRowW-1:0];
      CFG_ROT_ROW2:         rot_rows[2] = v[RotRowW-1:0];
      CFG_TRANSLATION:      trans_offs = v[TransW-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, let every pending point come out and the pipeline empty
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (NStages + 4) @(posedge clk);
  endtask

  // predict every sample beat the unit takes
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      pending_points.push_back(pin_on ? pin_point
                                      : project_sample(in_ch.depth, in_ch.row, in_ch.col));
    end
  end

  // compare each point beat with the oldest prediction; random back-pressure
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("point beat with no prediction pending");
      end else begin
        head_point = pending_points.pop_front();
        if (out_ch.point_x !== head_point.x)
          report_mismatch($sformatf("point_x got %0d want %0d", out_ch.point_x,
                                    head_point.x));
        if (out_ch.point_y !== head_point.y)
          report_mismatch($sformatf("point_y got %0d want %0d", out_ch.point_y,
                                    head_point.y));
        if (out_ch.point_z !== head_point.z)
          report_mismatch($sformatf("point_z got %0d want %0d", out_ch.point_z,
                                    head_point.z));
      end
      points_seen++;
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [CfgDataW-1:0] offsets;
    logic [DepthW-1:0]   d;
    longint              ext_w;
    longint              ext_h;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.depth  = '0;
    in_ch.row    = '0;
    in_ch.col    = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_FRAME_WIDTH;
    cfg_ch.data  = '0;
    pin_on       = 1'b0;
    pin_point    = '0;

    // directed rows: reset sizes, centre and corner pixels, bit patterns
    plan.push_back(pinned_row(16'd0, 10'd0, 10'd0, 0, 0, 0));
    plan.push_back(pinned_row(16'hFFFF, 10'd120, 10'd160, 0, 0, 1048560));
    plan.push_back(sample_row(16'hFFFF, 10'd0, 10'd0));
    plan.push_back(sample_row(16'hFFFF, 10'd1023, 10'd1023));
    plan.push_back(sample_row(16'd1, 10'd239, 10'd319));
    plan.push_back(sample_row(16'hAAAA, 10'h155, 10'h2AA));
    plan.push_back(sample_row(16'h5555, 10'h2AA, 10'h155));
    // zero frame size counts as one: far pixels saturate
    plan.push_back(write_row(CFG_FRAME_WIDTH, '0));
    plan.push_back(write_row(CFG_FRAME_HEIGHT, '0));
    plan.push_back(pinned_row(16'hFFFF, 10'd1023, 10'd1023, OutMin, OutMin, 1048560));
    plan.push_back(pinned_row(16'd0, 10'd1023, 10'd1023, 0, 0, 0));
    plan.push_back(sample_row(16'hFFFF, 10'd0, 10'd0));
    // oversize frame clamps to the limit
    plan.push_back(write_row(CFG_FRAME_WIDTH, CfgDataW'(11'h7FF)));
    plan.push_back(write_row(CFG_FRAME_HEIGHT, CfgDataW'(11'd1500)));
    plan.push_back(pinned_row(16'd40000, 10'd512, 10'd512, 0, 0, 640000));
    plan.push_back(sample_row(16'hFFFF, 10'd1023, 10'd0));
    // rigid transform with extreme coefficients and offsets
    plan.push_back(write_row(CFG_ROT_ROW0, CfgDataW'({16'h4000, 16'h7FFF, 16'h8000})));
    plan.push_back(write_row(CFG_ROT_ROW1, CfgDataW'({16'hFFFF, 16'h0000, 16'h7FFF})));
    plan.push_back(write_row(CFG_ROT_ROW2, CfgDataW'({16'h8000, 16'hC000, 16'h0001})));
    plan.push_back(write_row(CFG_TRANSLATION, {21'h0FFFFF, 21'h100000, 21'h000001}));
    plan.push_back(write_row(CFG_TRANSFORM_ENABLE, CfgDataW'(1)));
    plan.push_back(pinned_row(16'd0, 10'd0, 10'd0, 16, -16777216, 16777200));
    plan.push_back(sample_row(16'hFFFF, 10'd0, 10'd0));
    plan.push_back(sample_row(16'hFFFF, 10'd1023, 10'd1023));
    plan.push_back(sample_row(16'd12345, 10'd100, 10'd200));
    plan.push_back(write_row(CFG_TRANSFORM_ENABLE, '0));
    plan.push_back(sample_row(16'd1000, 10'd60, 10'd80));

    // synchronous reset, held low and then released
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        quiesce();
        write_register(plan[k].reg_idx, plan[k].value);
      end else begin
        send_sample(plan[k].depth, plan[k].row, plan[k].col, plan[k].pinned, plan[k].want);
      end
    end

    // random phases: fresh register settings and an idling mix taken in turn from four settings
    for (int ph = 0; ph < PhaseCount; ph++) begin
      quiesce();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 57; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      case ($urandom_range(4))
        0: offsets = '0;
        1: offsets = '1;
        2: offsets = {21'h0FFFFF, 21'h100000, 21'h0FFFFF};
        default: offsets = CfgDataW'({$urandom, $urandom});
      endcase
      write_register(CFG_FRAME_WIDTH, CfgDataW'(pick_dim()));
      write_register(CFG_FRAME_HEIGHT, CfgDataW'(pick_dim()));
      write_register(CFG_ROT_ROW0, CfgDataW'(pick_rot_row()));
      write_register(CFG_ROT_ROW1, CfgDataW'(pick_rot_row()));
      write_register(CFG_ROT_ROW2, CfgDataW'(pick_rot_row()));
      write_register(CFG_TRANSLATION, offsets);
      write_register(CFG_TRANSFORM_ENABLE, CfgDataW'($urandom_range(99) < 60));
      ext_w = active_extent(frame_w, MaxWidth);
      ext_h = active_extent(frame_h, MaxHeight);
      repeat (PhaseBeats) begin
        case ($urandom_range(7))
          0: d = '0;
          1: d = '1;
          default: d = DepthW'($urandom_range(65535, 0));
        endcase
        send_sample(d, rand_coord(ext_h), rand_coord(ext_w), 1'b0, '0);
      end
    end

    quiesce();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
